FILE: design/nafb_pkg.sv
// Shared types and constants for the nibble ASCII frame builder.
`timescale 1ns / 1ps

package nafb_pkg;

    localparam int MAX_FRAME_BITS_DEFAULT = 1024;
    localparam int QUEUE_DEPTH_DEFAULT    = 4;
    localparam logic [7:0] SEQ_LIMIT_RESET = 8'd200;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_D      = 8'h64;
    localparam logic [7:0] CHR_A      = 8'h61;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_USCORE = 8'h5F;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    // Byte positions inside one frame command
    typedef enum logic [3:0] {
        POS_DOLLAR = 4'd0,
        POS_D      = 4'd1,
        POS_A      = 4'd2,
        POS_T      = 4'd3,
        POS_USCORE = 4'd4,
        POS_SEQ    = 4'd5,
        POS_CNT_HI = 4'd6,
        POS_CNT_LO = 4'd7,
        POS_NIBBLE = 4'd8,
        POS_CHECK  = 4'd9,
        POS_CR     = 4'd10,
        POS_LF     = 4'd11
    } pos_t;

    // One classified word handed from the front end to the byte sequencer
    typedef struct packed {
        logic       first;
        logic       last;
        logic [3:0] nib;
        logic [7:0] seq;
        logic [7:0] cnt_hi;
        logic [7:0] cnt_lo;
    } cmd_t;

endpackage

FILE: design/nibble_ascii_frame_builder.sv
// Top level of the nibble ASCII frame builder.
`timescale 1ns / 1ps

// Builds ASCII framed packets from decoded nibbles. A word with first_nibble
// set opens a frame and yields the header "$dat_", the rolling sequence
// number and the nibble count (high byte, then low byte), followed by the
// nibble as an ASCII digit (nibble + 0x30). Later words yield one digit
// each; a word with last_nibble set adds the XOR of all earlier frame bytes,
// then CR and LF (frame_end marks the LF, run_last the final byte of each
// input word). Words outside an open frame are dropped. The sequence number
// counts up to cfg_data's limit (reset 200) and then wraps to zero; write
// the limit only while the block is idle. Input words are taken one per
// cycle while the command queue has room; the output side emits one byte
// per cycle while out_stall is low, so a middle word yields one byte, a
// header word nine and a closing word four. Sustained rate is set by the
// byte sequencer, which loads its output register and pops spent commands.

module nibble_ascii_frame_builder #(
    parameter int MAX_FRAME_BITS = nafb_pkg::MAX_FRAME_BITS_DEFAULT,
    parameter int QUEUE_DEPTH    = nafb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] nibble,
    input  logic [9:0] frame_bit_count,
    input  logic       first_nibble,
    input  logic       last_nibble,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic           q_full;
    logic           q_push;
    nafb_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           head_valid;
    nafb_pkg::cmd_t head_cmd;

    // Classify words, advance the sequence number at each frame start
    nafb_front #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .nibble          (nibble),
        .frame_bit_count (frame_bit_count),
        .first_nibble    (first_nibble),
        .last_nibble     (last_nibble),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_cmd)
    );

    // Hold commands while the sequencer works through a header or trailer
    nafb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Expand each command into bytes and drop it after its last byte
    nafb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

FILE: design/nafb_front.sv
// Front end: accepts nibble words, tracks frame state and sequence number.
`timescale 1ns / 1ps

module nafb_front #(
    parameter int MAX_FRAME_BITS = nafb_pkg::MAX_FRAME_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          nibble,
    input  logic [9:0]          frame_bit_count,
    input  logic                first_nibble,
    input  logic                last_nibble,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output nafb_pkg::cmd_t      q_cmd
);

    localparam int BW = $clog2(MAX_FRAME_BITS + 1);
    localparam int SW = (BW > 10) ? BW : 10;

    logic [7:0]    limit_reg;
    logic [7:0]    seq_reg;
    logic [7:0]    seq_next;
    logic          in_frame_reg;
    logic          accept;
    logic [SW-1:0] bits_ext;
    logic [SW-1:0] bits_sat;
    logic [SW-1:0] count;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign q_push    = accept && (first_nibble || in_frame_reg);

    // Saturate the bit count, then divide by four
    assign bits_ext = SW'(frame_bit_count);
    assign bits_sat = (bits_ext > SW'(MAX_FRAME_BITS)) ? SW'(MAX_FRAME_BITS) : bits_ext;
    assign count    = bits_sat >> 2;

    assign seq_next = (seq_reg < limit_reg) ? (seq_reg + 8'd1) : 8'd0;

    always_comb
    begin
        q_cmd.first  = first_nibble;
        q_cmd.last   = last_nibble;
        q_cmd.nib    = nibble;
        q_cmd.seq    = seq_next;
        q_cmd.cnt_hi = 8'(count >> 8);
        q_cmd.cnt_lo = count[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= nafb_pkg::SEQ_LIMIT_RESET;
            seq_reg      <= 8'd0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (q_push)
            begin
                if (first_nibble)
                begin
                    seq_reg <= seq_next;
                end
                in_frame_reg <= !last_nibble;
            end
        end
    end

endmodule

FILE: design/nafb_queue.sv
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module nafb_queue #(
    parameter int DEPTH = nafb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nafb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output nafb_pkg::cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nafb_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  fill_reg;
    logic [CW-1:0]  fill_next;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

FILE: design/nafb_back.sv
// Byte sequencer: expands each command into frame bytes, keeps the checksum.
`timescale 1ns / 1ps

module nafb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  nafb_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           frame_end
);

    logic            active_reg;
    nafb_pkg::pos_t  pos_reg;
    nafb_pkg::pos_t  pos;
    logic [7:0]      xor_reg;
    logic [7:0]      xor_base;
    logic [7:0]      byte_val;
    logic            final_byte;
    logic            load;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            run_last_reg;
    logic            frame_end_reg;

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && final_byte;

    // A fresh command starts at the header or straight at its nibble
    always_comb
    begin
        if (active_reg)
        begin
            pos = pos_reg;
        end
        else if (head_cmd.first)
        begin
            pos = nafb_pkg::POS_DOLLAR;
        end
        else
        begin
            pos = nafb_pkg::POS_NIBBLE;
        end
    end

    assign xor_base = (pos == nafb_pkg::POS_DOLLAR) ? 8'd0 : xor_reg;

    always_comb
    begin
        unique case (pos)
            nafb_pkg::POS_DOLLAR: byte_val = nafb_pkg::CHR_DOLLAR;
            nafb_pkg::POS_D:      byte_val = nafb_pkg::CHR_D;
            nafb_pkg::POS_A:      byte_val = nafb_pkg::CHR_A;
            nafb_pkg::POS_T:      byte_val = nafb_pkg::CHR_T;
            nafb_pkg::POS_USCORE: byte_val = nafb_pkg::CHR_USCORE;
            nafb_pkg::POS_SEQ:    byte_val = head_cmd.seq;
            nafb_pkg::POS_CNT_HI: byte_val = head_cmd.cnt_hi;
            nafb_pkg::POS_CNT_LO: byte_val = head_cmd.cnt_lo;
            nafb_pkg::POS_NIBBLE: byte_val = nafb_pkg::DIGIT_BASE + 8'(head_cmd.nib);
            nafb_pkg::POS_CHECK:  byte_val = xor_reg;
            nafb_pkg::POS_CR:     byte_val = nafb_pkg::CHR_CR;
            nafb_pkg::POS_LF:     byte_val = nafb_pkg::CHR_LF;
            default:              byte_val = 8'd0;
        endcase
    end

    assign final_byte = ((pos == nafb_pkg::POS_NIBBLE) && !head_cmd.last)
                     || (pos == nafb_pkg::POS_LF);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= byte_val;
            run_last_reg  <= final_byte;
            frame_end_reg <= (pos == nafb_pkg::POS_LF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= nafb_pkg::POS_DOLLAR;
            xor_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                xor_reg       <= xor_base ^ byte_val;
                active_reg    <= !final_byte;
                pos_reg       <= nafb_pkg::pos_t'(pos + 4'd1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule
